### rtl/adp_pkg.sv
`default_nettype none
package adp_pkg;

  localparam int PARAM_COUNT = 4096;
  localparam int IDX_W       = $clog2(PARAM_COUNT);

  localparam int M_W   = 32;
  localparam int V_W   = 48;
  localparam int MEM_W = M_W + V_W;

  localparam int NUM_W = 88;
  localparam int DIV_W = 49;
  localparam int CNT_W = 7;

  localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] CFG_BETA_FIRST    = 2'd1;
  localparam logic [1:0] CFG_BETA_SECOND   = 2'd2;
  localparam logic [1:0] CFG_EPSILON_TERM  = 2'd3;

  localparam logic [23:0] RST_LEARNING_RATE = 24'd16777;
  localparam logic [15:0] RST_BETA_FIRST    = 16'd58982;
  localparam logic [15:0] RST_BETA_SECOND   = 16'd65470;
  localparam logic [23:0] RST_EPSILON_TERM  = 24'd1;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } adp_op_t;

  typedef struct packed {
    logic             go;
    adp_op_t          op;
    logic [CNT_W-1:0] count;
  } adp_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } adp_sts_t;

endpackage
`default_nettype wire

### rtl/adp_ram.sv
`default_nettype none
module adp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/adp_shsub.sv
`default_nettype none
module adp_shsub
  import adp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire adp_cmd_t         cmd,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DIV_W-1:0] divisor,
  output adp_sts_t              sts,
  output logic      [NUM_W-1:0] result
);

  adp_op_t          op_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] qt_r;
  logic [DIV_W-1:0] div_r;
  logic [DIV_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DIV_W:0]   r2;
  logic [DIV_W:0]   sub;
  logic [DIV_W+1:0] diff;
  logic             ge;

  always_comb begin
    if (op_r == OP_DIV) begin
      r2  = {rem_r, num_r[NUM_W-1]};
      sub = {1'b0, div_r};
    end else begin
      r2  = {rem_r[DIV_W-2:0], num_r[NUM_W-1:NUM_W-2]};
      sub = {16'b0, qt_r[31:0], 2'b01};
    end
    diff = {1'b0, r2} - {1'b0, sub};
    ge   = !diff[DIV_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.go) begin
        op_r   <= cmd.op;
        num_r  <= num;
        div_r  <= divisor;
        rem_r  <= '0;
        qt_r   <= '0;
        cnt_r  <= cmd.count;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
        qt_r  <= {qt_r[NUM_W-2:0], ge};
        num_r <= (op_r == OP_DIV) ? {num_r[NUM_W-2:0], 1'b0} : {num_r[NUM_W-3:0], 2'b00};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = qt_r;

`ifndef NO_ASSERTIONS
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) cmd.go |-> !busy_r)
    else $error("start while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("done without work");
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
      (busy_r && !cmd.go) |-> (cnt_r != '0))
    else $error("busy with zero count");
`endif

endmodule
`default_nettype wire

### rtl/adam_parameter_update.sv
`default_nettype none
// Adam update of one Q8.24 weight element per request. Per-index moments live in one
// 80-bit by 4096-entry memory; after reset a clearing pass zeroes it, and in_stall stays
// high meanwhile (configuration writes are taken throughout). For each request the shared
// shift-subtract unit runs one bit per cycle for the bias-corrected first moment, the two
// square roots, the denominator ratio and the final step quotient, with the moment update,
// multiply, unit start and finish, and sequencing around them.
// One request is in flight at a time; the result sits in an output register, so the next
// request may enter while it waits, and a request only finishes once that register is free.
module adam_parameter_update
  import adp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_start_step,
  input  wire logic [11:0] in_param_index,
  input  wire logic [31:0] in_weight_value,
  input  wire logic [31:0] in_grad_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_new_weight,
  output logic             out_saturated
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_G2, ST_M1, ST_M2, ST_V1, ST_V2,
    ST_MH_GO, ST_MH_WT, ST_SV_GO, ST_SV_WT, ST_SC_GO, ST_SC_WT,
    ST_DN_GO, ST_DN_WT, ST_MUL1, ST_MUL2, ST_ST_GO, ST_ST_WT, ST_FIN
  } state_t;

  state_t state_r;

  logic [23:0] eta_r;
  logic [15:0] b1_r;
  logic [15:0] b2_r;
  logic [23:0] eps_r;

  logic [32:0] p1_r;
  logic [32:0] p2_r;
  logic        started_r;
  logic [IDX_W-1:0] clr_r;

  logic [IDX_W-1:0] idx_r;
  logic signed [31:0] w_r;
  logic signed [31:0] g_r;
  logic [47:0] g2_r;
  logic signed [50:0] macc_r;
  logic signed [31:0] m_r;
  logic [63:0] vacc_r;
  logic [47:0] v_r;
  logic [63:0] mh_r;
  logic [31:0] sv_r;
  logic [31:0] sc_r;
  logic [48:0] den_r;
  logic [55:0] plo_r;
  logic [87:0] prod_r;
  logic [33:0] step_r;

  logic        out_valid_r;
  logic [31:0] out_w_r;
  logic        out_sat_r;

  logic        ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [MEM_W-1:0] ram_wdata;
  logic [MEM_W-1:0] ram_rdata;

  adp_cmd_t         cmd;
  adp_sts_t         sts;
  logic [NUM_W-1:0] unit_num;
  logic [DIV_W-1:0] unit_div;
  logic [NUM_W-1:0] unit_q;

  logic        accept;
  logic        advance;
  logic [48:0] p1m;
  logic [48:0] p2m;
  logic [31:0] gmag;
  logic [63:0] gsq;
  logic signed [31:0] m_old;
  logic [47:0] v_old;
  logic signed [48:0] mb_prod;
  logic [16:0] omb1;
  logic [16:0] omb2;
  logic signed [49:0] mg_prod;
  logic signed [50:0] msum;
  logic [31:0] m_nxt;
  logic [63:0] vb_prod;
  logic [64:0] vg_prod;
  logic [64:0] vsum;
  logic [47:0] v_nxt;
  logic [32:0] c1_raw;
  logic [32:0] c1;
  logic [32:0] c2_raw;
  logic [32:0] c2;
  logic [31:0] mmag;
  logic [48:0] dsum;
  logic [48:0] den_nxt;
  logic [55:0] phi;
  logic [87:0] prod_nxt;
  logic [33:0] step_nxt;
  logic [34:0] wext;
  logic [34:0] sext;
  logic [34:0] res;
  logic        pos_ovf;
  logic        neg_ovf;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign advance  = in_start_step || !started_r;

  always_comb begin
    p1m      = {16'b0, p1_r} * {33'b0, b1_r};
    p2m      = {16'b0, p2_r} * {33'b0, b2_r};
    gmag     = g_r[31] ? 32'(-g_r) : g_r;
    gsq      = {32'b0, gmag} * {32'b0, gmag};
    m_old    = ram_rdata[MEM_W-1:V_W];
    v_old    = ram_rdata[V_W-1:0];
    omb1     = 17'h10000 - {1'b0, b1_r};
    omb2     = 17'h10000 - {1'b0, b2_r};
    mb_prod  = $signed({1'b0, b1_r}) * m_old;
    mg_prod  = $signed({1'b0, omb1}) * g_r;
    msum     = macc_r + {mg_prod[49], mg_prod};
    m_nxt    = msum[47:16];
    vb_prod  = {48'b0, b2_r} * {16'b0, v_old};
    vg_prod  = {48'b0, omb2} * {17'b0, g2_r};
    vsum     = {1'b0, vacc_r} + vg_prod;
    v_nxt    = vsum[63:16];
    c1_raw   = ONE_Q32 - p1_r;
    c1       = (c1_raw == '0) ? 33'd1 : c1_raw;
    c2_raw   = ONE_Q32 - p2_r;
    c2       = (c2_raw == '0) ? 33'd1 : c2_raw;
    mmag     = m_r[31] ? 32'(-m_r) : m_r;
    dsum     = {1'b0, unit_q[47:0]} + {25'b0, eps_r};
    den_nxt  = (dsum == '0) ? 49'd1 : dsum;
    phi      = {32'b0, eta_r} * {24'b0, mh_r[63:32]};
    prod_nxt = {32'b0, plo_r} + {phi, 32'b0};
    if ((|unit_q[87:34]) || (unit_q[33] && (|unit_q[32:0]))) begin
      step_nxt = {1'b1, 33'b0};
    end else begin
      step_nxt = unit_q[33:0];
    end
    wext     = {{3{w_r[31]}}, w_r};
    sext     = {1'b0, step_r};
    res      = m_r[31] ? (wext + sext) : (wext - sext);
    pos_ovf  = !res[34] && (|res[33:31]);
    neg_ovf  = res[34] && !(&res[33:31]);
  end

  always_comb begin
    cmd.go    = 1'b0;
    cmd.op    = OP_DIV;
    cmd.count = CNT_W'(64);
    unit_num  = {mmag, 56'b0};
    unit_div  = {16'b0, c1};
    case (state_r)
      ST_MH_GO: begin
        cmd.go = 1'b1;
      end
      ST_SV_GO: begin
        cmd.go    = 1'b1;
        cmd.op    = OP_SQRT;
        cmd.count = CNT_W'(32);
        unit_num  = {v_r, 40'b0};
      end
      ST_SC_GO: begin
        cmd.go    = 1'b1;
        cmd.op    = OP_SQRT;
        cmd.count = CNT_W'(32);
        unit_num  = {1'b0, c2, 54'b0};
      end
      ST_DN_GO: begin
        cmd.go   = 1'b1;
        unit_num = {1'b0, sv_r, 55'b0};
        unit_div = {17'b0, sc_r};
      end
      ST_ST_GO: begin
        cmd.go    = 1'b1;
        cmd.count = CNT_W'(88);
        unit_num  = prod_r;
        unit_div  = den_r;
      end
      default: begin
        cmd.go = 1'b0;
      end
    endcase
  end

  assign ram_we    = (state_r == ST_CLEAR) || (state_r == ST_V2);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : idx_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : {m_r, v_nxt};

  adp_ram #(
    .WIDTH(MEM_W),
    .DEPTH(PARAM_COUNT)
  ) u_mom (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  adp_shsub u_shsub (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .num    (unit_num),
    .divisor(unit_div),
    .sts    (sts),
    .result (unit_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      idx_r       <= '0;
      started_r   <= 1'b0;
      p1_r        <= ONE_Q32;
      p2_r        <= ONE_Q32;
      eta_r       <= RST_LEARNING_RATE;
      b1_r        <= RST_BETA_FIRST;
      b2_r        <= RST_BETA_SECOND;
      eps_r       <= RST_EPSILON_TERM;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEARNING_RATE: eta_r <= cfg_wdata;
          CFG_BETA_FIRST:    b1_r  <= cfg_wdata[15:0];
          CFG_BETA_SECOND:   b2_r  <= cfg_wdata[15:0];
          CFG_EPSILON_TERM:  eps_r <= cfg_wdata;
          default:           eta_r <= eta_r;
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IDX_W'(PARAM_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            idx_r <= IDX_W'(in_param_index % PARAM_COUNT);
            w_r   <= in_weight_value;
            g_r   <= in_grad_value;
            if (advance) begin
              p1_r <= p1m[48:16];
              p2_r <= p2m[48:16];
            end
            started_r <= 1'b1;
            state_r   <= ST_READ;
          end
        end
        ST_READ: state_r <= ST_G2;
        ST_G2: begin
          g2_r    <= gsq[63:16];
          state_r <= ST_M1;
        end
        ST_M1: begin
          macc_r  <= {{2{mb_prod[48]}}, mb_prod};
          state_r <= ST_M2;
        end
        ST_M2: begin
          m_r     <= m_nxt;
          state_r <= ST_V1;
        end
        ST_V1: begin
          vacc_r  <= vb_prod;
          state_r <= ST_V2;
        end
        ST_V2: begin
          v_r     <= v_nxt;
          state_r <= ST_MH_GO;
        end
        ST_MH_GO: state_r <= ST_MH_WT;
        ST_MH_WT: begin
          if (sts.done) begin
            mh_r    <= unit_q[63:0];
            state_r <= ST_SV_GO;
          end
        end
        ST_SV_GO: state_r <= ST_SV_WT;
        ST_SV_WT: begin
          if (sts.done) begin
            sv_r    <= unit_q[31:0];
            state_r <= ST_SC_GO;
          end
        end
        ST_SC_GO: state_r <= ST_SC_WT;
        ST_SC_WT: begin
          if (sts.done) begin
            sc_r    <= unit_q[31:0];
            state_r <= ST_DN_GO;
          end
        end
        ST_DN_GO: state_r <= ST_DN_WT;
        ST_DN_WT: begin
          if (sts.done) begin
            den_r   <= den_nxt;
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          plo_r   <= {32'b0, eta_r} * {24'b0, mh_r[31:0]};
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          prod_r  <= prod_nxt;
          state_r <= ST_ST_GO;
        end
        ST_ST_GO: state_r <= ST_ST_WT;
        ST_ST_WT: begin
          if (sts.done) begin
            step_r  <= step_nxt;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            if (pos_ovf) begin
              out_w_r <= 32'h7FFF_FFFF;
            end else if (neg_ovf) begin
              out_w_r <= 32'h8000_0000;
            end else begin
              out_w_r <= res[31:0];
            end
            out_sat_r   <= pos_ovf || neg_ovf;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_weight = out_w_r;
  assign out_saturated  = out_sat_r;

`ifndef NO_ASSERTIONS
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
      accept |=> (state_r == ST_READ))
    else $error("request not taken into read");
  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_FIN && !out_valid_r) |=> out_valid_r)
    else $error("result not presented");
  a_start_flag: assert property (@(posedge clk) disable iff (!rst_n)
      $rose(started_r) |-> $past(accept))
    else $error("step flag set without request");
`endif

endmodule
`default_nettype wire

### bench/tb_top.sv
`default_nettype none
module tb_top
  import adp_pkg::*;
();

  class adam_scoreboard;
    bit [23:0] rate, eps;
    bit [15:0] beta1, beta2;
    bit [31:0] m_store [PARAM_COUNT];
    bit [47:0] v_store [PARAM_COUNT];
    bit [63:0] pow1, pow2;
    bit        begun;
    bit [31:0] pending_weight [$];
    bit        pending_sat [$];
    int        errors;

    function new();
      rate   = RST_LEARNING_RATE;
      beta1  = RST_BETA_FIRST;
      beta2  = RST_BETA_SECOND;
      eps    = RST_EPSILON_TERM;
      pow1   = 64'(ONE_Q32);
      pow2   = 64'(ONE_Q32);
      begun  = 0;
      errors = 0;
      foreach (m_store[i]) begin
        m_store[i] = '0;
        v_store[i] = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        CFG_LEARNING_RATE: rate  = data;
        CFG_BETA_FIRST:    beta1 = data[15:0];
        CFG_BETA_SECOND:   beta2 = data[15:0];
        CFG_EPSILON_TERM:  eps   = data;
        default: ;
      endcase
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x   = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void note_request(bit start, bit [11:0] idx, bit [31:0] wv, bit [31:0] gv);
      longint    w, g, mm, res;
      bit [63:0] gmag, g2, c1, c2, mmag, mh, sv, sc, den, step;
      bit [127:0] vacc, prod, quot;
      bit [47:0] v;
      bit        sat;
      if (start || !begun) begin
        pow1  = (pow1 * beta1) >> 16;
        pow2  = (pow2 * beta2) >> 16;
        begun = 1;
      end
      w    = longint'(signed'(wv));
      g    = longint'(signed'(gv));
      gmag = (g < 0) ? -g : g;
      g2   = (gmag * gmag) >> 16;
      mm   = (longint'(beta1) * longint'(signed'(m_store[idx]))
             + longint'(65536 - beta1) * g) >>> 16;
      m_store[idx] = mm[31:0];
      vacc = 128'(beta2) * v_store[idx] + 128'(65536 - beta2) * g2;
      v    = vacc[63:16];
      v_store[idx] = v;
      c1 = 64'(ONE_Q32) - ((pow1 > 64'(ONE_Q32)) ? 64'(ONE_Q32) : pow1);
      c2 = 64'(ONE_Q32) - ((pow2 > 64'(ONE_Q32)) ? 64'(ONE_Q32) : pow2);
      if (c1 == 0) c1 = 1;
      if (c2 == 0) c2 = 1;
      mmag = (mm < 0) ? -mm : mm;
      mh   = (mmag << 32) / c1;
      sv   = int_sqrt({v, 16'd0});
      sc   = int_sqrt(c2 << 30);
      den  = ((sv << 31) / sc) + eps;
      if (den == 0) den = 1;
      prod = 128'(rate) * mh;
      quot = prod / den;
      step = (quot > (128'd1 << 33)) ? (64'd1 << 33) : quot[63:0];
      res  = (mm >= 0) ? w - longint'(step) : w + longint'(step);
      sat  = 0;
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647;
        sat = 1;
      end else if (res < -64'sd2147483648) begin
        res = -64'sd2147483648;
        sat = 1;
      end
      pending_weight.push_back(res[31:0]);
      pending_sat.push_back(sat);
    endfunction

    function void check_result(bit [31:0] nw, bit s);
      bit [31:0] ew;
      bit        es;
      if (pending_weight.size() == 0) begin
        $display("%0t: unexpected result new_weight=%h saturated=%b", $time, nw, s);
        errors++;
        return;
      end
      ew = pending_weight.pop_front();
      es = pending_sat.pop_front();
      if (ew !== nw) begin
        $display("%0t: new_weight expected %h actual %h", $time, ew, nw);
        errors++;
      end
      if (es !== s) begin
        $display("%0t: saturated expected %b actual %b", $time, es, s);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_start_step;
  logic [11:0] in_param_index;
  logic [31:0] in_weight_value;
  logic [31:0] in_grad_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_new_weight;
  logic        out_saturated;

  adam_scoreboard board;
  int send_idle_pct;
  int recv_stall_pct;

  adam_parameter_update dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 4_000_000);
    $display("tb_top: done, errors");
    $finish;
  end

  // check results, then pick next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_new_weight, out_saturated);
    out_stall <= rst_n && (recv_stall_pct > 0)
                 && ($urandom_range(99, 0) < recv_stall_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    board.set_reg(idx, data);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(logic [23:0] r, logic [15:0] b1, logic [15:0] b2,
                           logic [23:0] e);
    write_reg(CFG_LEARNING_RATE, r);
    write_reg(CFG_BETA_FIRST, {8'd0, b1});
    write_reg(CFG_BETA_SECOND, {8'd0, b2});
    write_reg(CFG_EPSILON_TERM, e);
  endtask

  task automatic send_request(bit start, bit [11:0] idx, bit [31:0] w, bit [31:0] g);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_start_step   <= start;
    in_param_index  <= idx;
    in_weight_value <= w;
    in_grad_value   <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(start, idx, w, g);
  endtask

  task automatic drain();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (board.pending_weight.size() != 0 && n < 200_000) begin
      @(posedge clk);
      n++;
    end
    repeat (400) @(posedge clk);
  endtask

  function automatic bit [31:0] rand_grad();
    case ($urandom_range(3, 0))
      0:       return $urandom();
      1:       return 32'(signed'($urandom_range(1 << 24, 0)) - (1 << 23));
      default: return 32'(signed'($urandom_range(1 << 20, 0)) - (1 << 19));
    endcase
  endfunction

  initial begin
    int ph, k;
    bit [11:0] base;
    board           = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_start_step   = 1'b0;
    in_param_index  = '0;
    in_weight_value = '0;
    in_grad_value   = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, first request before any start
    send_request(0, 12'd0, 32'd0, 32'h7fff_ffff);
    send_request(0, 12'd4095, 32'h7fff_ffff, 32'h8000_0000);
    send_request(1, 12'd0, 32'h8000_0000, 32'h7fff_ffff);
    send_request(0, 12'd1, 32'h0100_0000, 32'd0);
    send_request(1, 12'd2, 32'hff00_0000, 32'hffff_ffff);
    send_request(0, 12'd2, 32'h0000_0001, 32'h0000_0001);
    drain();

    // zero betas, zero epsilon, full rate
    write_all(24'hff_ffff, 16'd0, 16'd0, 24'd0);
    send_request(1, 12'd100, 32'h1234_5678, 32'd0);
    send_request(0, 12'd101, 32'h7fff_ffff, 32'h8000_0000);
    send_request(0, 12'd102, 32'h8000_0000, 32'h7fff_ffff);
    send_request(1, 12'd103, 32'h7f00_0000, 32'hf000_0000);
    drain();

    // maximum betas, first zero rate and maximum epsilon, then full rate and epsilon of one
    write_all(24'd0, 16'hffff, 16'hffff, 24'hff_ffff);
    send_request(1, 12'd200, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(0, 12'd200, 32'h8000_0000, 32'h8000_0000);
    drain();
    write_all(24'hff_ffff, 16'hffff, 16'hffff, 24'd1);
    send_request(1, 12'd201, 32'h7fff_fff0, 32'h8000_0000);
    send_request(0, 12'd201, 32'h8000_0010, 32'h7fff_ffff);
    send_request(1, 12'd202, 32'h0, 32'h0000_0100);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (ph == 0)
        write_all(RST_LEARNING_RATE, RST_BETA_FIRST, RST_BETA_SECOND, RST_EPSILON_TERM);
      else
        write_all(24'($urandom_range(24'hff_ffff, 0)),
                  16'($urandom_range(16'hffff, 16'h8000)),
                  16'($urandom_range(16'hffff, 16'hf000)),
                  24'($urandom_range(255, 0)));
      base = 12'($urandom());
      for (k = 0; k < 54; k++) begin
        if ($urandom_range(9, 0) == 0)
          send_request(1'($urandom_range(1, 0)), 12'($urandom()), $urandom(), $urandom());
        else
          send_request(($urandom_range(7, 0) == 0), base + 12'($urandom_range(7, 0)),
                       $urandom(), rand_grad());
      end
      drain();
    end

    if (board.errors == 0 && board.pending_weight.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
